>>> hw/rtl/iss_pkg.sv
// Shared constants, command and status codes, and cell control type for the sequence store.
package iss_pkg;

    // Storage shape
    localparam int DEPTH     = 256;
    localparam int WORD_BITS = 32;

    // Fixed field widths of the channels
    localparam int CMD_BITS      = 3;
    localparam int VALUE_BITS    = 32;
    localparam int INDEX_BITS    = 9;
    localparam int STATUS_BITS   = 2;
    localparam int POSITION_BITS = 8;
    localparam int COUNT_BITS    = 9;

    // Derived widths
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > INDEX_BITS) ? CNT_W : INDEX_BITS;

    // First-match search: groups of sixteen cells, then one pick over the groups
    localparam int GRP_SIZE  = 16;
    localparam int GRP_OFS_W = 4;
    localparam int GRP_NUM   = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_IDX_W = (GRP_NUM > 1) ? $clog2(GRP_NUM) : 1;
    localparam int MATCH_W   = GRP_NUM * GRP_SIZE;
    localparam int FPOS_W    = GRP_IDX_W + GRP_OFS_W;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_INSERT_AT  = 3'd4,
        CMD_REMOVE_AT  = 3'd5,
        CMD_SEARCH     = 3'd6,
        CMD_CLEAR      = 3'd7
    } t_cmd;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                 wr_en;   // shift the row this cycle
        logic                 ins;     // 1: open a gap at pos, 0: close the gap at pos
        logic [IDX_W-1:0]     pos;
        logic [WORD_BITS-1:0] word;    // word to insert or to compare against
        logic                 cmp_en;  // capture the compare result
        logic [CNT_W-1:0]     count;   // entries held before this command
    } t_cell_ctl;

endpackage

>>> hw/rtl/iss_if.sv
// Command and response channel interfaces of the sequence store.
interface iss_cmd_if;
    import iss_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [CMD_BITS-1:0]          cmd;
    logic signed [VALUE_BITS-1:0] value;
    logic [INDEX_BITS-1:0]        index;

    modport source (output valid, cmd, value, index, input ready);
    modport sink   (input valid, cmd, value, index, output ready);
endinterface

interface iss_rsp_if;
    import iss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_BITS-1:0]   status;
    logic                     found;
    logic [POSITION_BITS-1:0] position;
    logic [COUNT_BITS-1:0]    count;

    modport source (output valid, status, found, position, count, input ready);
    modport sink   (input valid, status, found, position, count, output ready);
endinterface

>>> hw/rtl/iss_cell.sv
// One storage cell of the row: holds a word, shifts with its neighbors, compares.
module iss_cell
    import iss_pkg::*;
(
    input  logic                 i_clk,
    input  logic [IDX_W-1:0]     i_slot,
    input  t_cell_ctl            i_ctl,
    input  logic [WORD_BITS-1:0] i_left,
    input  logic [WORD_BITS-1:0] i_right,
    output logic [WORD_BITS-1:0] o_word,
    output logic                 o_match
);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic                 r_match;
    logic                 n_match;

    // Pick the next word: hold, take the new word, or take a neighbor's word
    always_comb begin
        n_word = r_word;
        if (i_ctl.wr_en) begin
            if (i_ctl.ins) begin
                if (i_slot == i_ctl.pos) begin
                    n_word = i_ctl.word;
                end else if (i_slot > i_ctl.pos) begin
                    n_word = i_left;
                end
            end else if (i_slot >= i_ctl.pos) begin
                n_word = i_right;
            end
        end
    end

    // Compare only entries that are held
    always_comb begin
        n_match = r_match;
        if (i_ctl.cmp_en) begin
            n_match = (CNT_W'(i_slot) < i_ctl.count) && (r_word == i_ctl.word);
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_match <= n_match;
    end

    assign o_word  = r_word;
    assign o_match = r_match;

endmodule

>>> hw/rtl/iss_first_match.sv
// First set bit of the match row: registered per-group pick, then pick over groups.
module iss_first_match
    import iss_pkg::*;
(
    input  logic               i_clk,
    input  logic [MATCH_W-1:0] i_match,
    output logic               o_found,
    output logic [FPOS_W-1:0]  o_position
);

    logic [GRP_NUM-1:0]   r_grp_hit;
    logic [GRP_OFS_W-1:0] r_grp_ofs [GRP_NUM];
    logic [GRP_NUM-1:0]   n_grp_hit;
    logic [GRP_OFS_W-1:0] n_grp_ofs [GRP_NUM];

    // Lowest set bit inside each group of sixteen
    always_comb begin
        for (int g = 0; g < GRP_NUM; g++) begin
            n_grp_hit[g] = |i_match[g*GRP_SIZE +: GRP_SIZE];
            n_grp_ofs[g] = '0;
            for (int b = GRP_SIZE - 1; b >= 0; b--) begin
                if (i_match[g*GRP_SIZE + b]) begin
                    n_grp_ofs[g] = GRP_OFS_W'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_hit <= n_grp_hit;
        for (int g = 0; g < GRP_NUM; g++) begin
            r_grp_ofs[g] <= n_grp_ofs[g];
        end
    end

    // Lowest group with a hit
    always_comb begin
        o_found    = |r_grp_hit;
        o_position = '0;
        for (int g = GRP_NUM - 1; g >= 0; g--) begin
            if (r_grp_hit[g]) begin
                o_position = {GRP_IDX_W'(g), r_grp_ofs[g]};
            end
        end
    end

endmodule

>>> hw/rtl/indexed_sequence_store.sv
// Top level of the indexed sequence store: command decode, cell row and response register.
//
//  channel  | dir | payload                          | beat
//  ---------+-----+----------------------------------+---------------------
//  i_cmd    | in  | cmd, value, index                | valid && ready
//  o_rsp    | out | status, found, position, count   | valid && ready
//
// Push, pop, insert and remove shift every cell in parallel; clear only resets the fill level.
// Search runs in steps: registered cell compares, registered per-group pick, pick over groups.
// One command is in flight at a time; a waiting response holds i_cmd.ready low
// only until it is taken, and a response taken in the same cycle frees the slot.
// Synchronous active-low reset empties the store; the cell words keep old data.
module indexed_sequence_store
    import iss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    iss_cmd_if.sink    i_cmd,
    iss_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH_A,
        S_SRCH_B
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic                 r_out_found;
    logic [IDX_W-1:0]     r_out_pos;
    logic [CNT_W-1:0]     r_out_count;
    t_status              r_pend_status;

    logic                 accept;
    logic                 out_load;
    t_cmd                 cmd_e;
    logic [WORD_BITS-1:0] word;
    logic                 full;
    logic                 empty;
    logic [CMP_W-1:0]     idx_ext;
    logic [CMP_W-1:0]     cnt_ext;

    t_status              d_status;
    logic                 d_wr;
    logic                 d_ins;
    logic [IDX_W-1:0]     d_pos;
    logic                 d_srch;
    logic [CNT_W-1:0]     d_count;

    t_cell_ctl            ctl;
    logic [WORD_BITS-1:0] w_word [DEPTH];
    logic [MATCH_W-1:0]   w_match;
    logic                 fm_found;
    logic [FPOS_W-1:0]    fm_pos;

    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_cmd.valid && i_cmd.ready;

    // Response register loads this cycle
    assign out_load = (accept && !d_srch) || (r_state == S_SRCH_B);

    assign cmd_e   = t_cmd'(i_cmd.cmd);
    assign word    = WORD_BITS'(i_cmd.value);
    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign idx_ext = CMP_W'(i_cmd.index);
    assign cnt_ext = CMP_W'(r_count);

    // Decode the command against the current fill level
    always_comb begin
        d_status = ST_OK;
        d_wr     = 1'b0;
        d_ins    = 1'b1;
        d_pos    = '0;
        d_srch   = 1'b0;
        d_count  = r_count;
        unique case (cmd_e)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (full) begin
                    d_status = ST_FULL;
                end else begin
                    d_wr    = 1'b1;
                    d_pos   = (cmd_e == CMD_PUSH_FRONT) ? '0 : IDX_W'(r_count);
                    d_count = r_count + CNT_W'(1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (empty) begin
                    d_status = ST_EMPTY;
                end else begin
                    d_wr    = 1'b1;
                    d_ins   = 1'b0;
                    d_pos   = (cmd_e == CMD_POP_FRONT) ? '0 : IDX_W'(r_count - CNT_W'(1));
                    d_count = r_count - CNT_W'(1);
                end
            end
            CMD_INSERT_AT: begin
                if (idx_ext > cnt_ext) begin
                    d_status = ST_BAD_INDEX;
                end else if (full) begin
                    d_status = ST_FULL;
                end else begin
                    d_wr    = 1'b1;
                    d_pos   = IDX_W'(i_cmd.index);
                    d_count = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE_AT: begin
                if (empty) begin
                    d_status = ST_EMPTY;
                end else if (idx_ext >= cnt_ext) begin
                    d_status = ST_BAD_INDEX;
                end else begin
                    d_wr    = 1'b1;
                    d_ins   = 1'b0;
                    d_pos   = IDX_W'(i_cmd.index);
                    d_count = r_count - CNT_W'(1);
                end
            end
            CMD_SEARCH: begin
                d_srch = 1'b1;
                if (empty) begin
                    d_status = ST_EMPTY;
                end
            end
            CMD_CLEAR: begin
                d_count = '0;
            end
            default: begin
                d_status = ST_OK;
            end
        endcase
    end

    // Broadcast to the row
    always_comb begin
        ctl.wr_en  = accept && d_wr;
        ctl.ins    = d_ins;
        ctl.pos    = d_pos;
        ctl.word   = word;
        ctl.cmp_en = accept && d_srch;
        ctl.count  = r_count;
    end

    // Row of cells, each wired to its two neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_BITS-1:0] left_word;
        logic [WORD_BITS-1:0] right_word;

        if (i == 0) begin : g_first
            assign left_word = w_word[0];
        end else begin : g_mid_l
            assign left_word = w_word[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_word = w_word[DEPTH-1];
        end else begin : g_mid_r
            assign right_word = w_word[i+1];
        end

        iss_cell u_cell (
            .i_clk   (i_clk),
            .i_slot  (IDX_W'(i)),
            .i_ctl   (ctl),
            .i_left  (left_word),
            .i_right (right_word),
            .o_word  (w_word[i]),
            .o_match (w_match[i])
        );
    end

    // Pad the match row up to whole groups
    if (MATCH_W > DEPTH) begin : g_pad
        assign w_match[MATCH_W-1:DEPTH] = '0;
    end

    iss_first_match u_first_match (
        .i_clk      (i_clk),
        .i_match    (w_match),
        .o_found    (fm_found),
        .o_position (fm_pos)
    );

    // Sequence commands, hold the fill level and the response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_count <= d_count;
                        if (d_srch) begin
                            r_pend_status <= d_status;
                            r_state       <= S_SRCH_A;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= d_status;
                            r_out_found  <= 1'b0;
                            r_out_pos    <= '0;
                            r_out_count  <= d_count;
                        end
                    end
                end
                S_SRCH_A: begin
                    r_state <= S_SRCH_B;
                end
                S_SRCH_B: begin
                    r_out_valid  <= 1'b1;
                    r_out_status <= r_pend_status;
                    r_out_found  <= fm_found;
                    r_out_pos    <= fm_found ? IDX_W'(fm_pos) : '0;
                    r_out_count  <= r_count;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.found    = r_out_found;
    assign o_rsp.position = POSITION_BITS'(r_out_pos);
    assign o_rsp.count    = COUNT_BITS'(r_out_count);

endmodule
